>>> hw/rtl/lgbb_pkg.sv
// Package with shared constants and types for the label group bounding box block.
`timescale 1ns / 1ps

package lgbb_pkg;

  localparam int SizeWidth = 16;

  localparam logic [0:0] LgbbRegMaxSize = 1'b0;
  localparam logic [0:0] LgbbRegMinSize = 1'b1;

  localparam logic [SizeWidth-1:0] LgbbMaxSizeReset = 16'd3840;
  localparam logic [SizeWidth-1:0] LgbbMinSizeReset = 16'd51;

  // Record queue depth; a power of two so that the pointers wrap naturally.
  localparam int LgbbFifoDepth = 4;

  typedef struct packed {
    logic push_a;
    logic push_b;
  } lgbb_push_t;

endpackage

>>> hw/rtl/lgbb_close.sv
// Box closing logic: center, size and size window check for one group.
`timescale 1ns / 1ps

module lgbb_close
  import lgbb_pkg::*;
#(
  parameter int CW = 16
) (
  input  logic [2:0][CW-1:0]     hi_i,
  input  logic [2:0][CW-1:0]     lo_i,
  input  logic [SizeWidth-1:0]   max_size_i,
  input  logic [SizeWidth-1:0]   min_size_i,
  output logic [2:0][CW-1:0]     center_o,
  output logic [2:0][CW-1:0]     size_o,
  output logic                   ok_o
);

  localparam int CmpW = (CW > SizeWidth) ? CW : SizeWidth;

  logic [2:0][CW-1:0] diff;
  logic [2:0][CW:0]   sum;
  logic [2:0]         axis_ok;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a]    = hi_i[a] - lo_i[a];
      sum[a]     = {hi_i[a][CW-1], hi_i[a]} + {lo_i[a][CW-1], lo_i[a]};
      axis_ok[a] = (CmpW'(diff[a]) <= CmpW'(max_size_i)) &&
                   (CmpW'(diff[a]) >= CmpW'(min_size_i));
    end
    ok_o = &axis_ok;
    for (int a = 0; a < 3; a++) begin
      center_o[a] = ok_o ? sum[a][CW:1] : '0;
      size_o[a]   = ok_o ? diff[a] : '0;
    end
  end

endmodule

>>> hw/rtl/lgbb_fifo.sv
// Small record queue that takes up to two records per cycle and gives one.
`timescale 1ns / 1ps

module lgbb_fifo
  import lgbb_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lgbb_push_t       push_i,
  input  logic [WIDTH-1:0] data_a_i,
  input  logic [WIDTH-1:0] data_b_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             not_empty_o,
  output logic             room2_o
);

  localparam int PtrW = $clog2(LgbbFifoDepth);
  localparam int CntW = $clog2(LgbbFifoDepth + 1);

  logic [WIDTH-1:0] mem [LgbbFifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  n_push;
  logic             do_pop;

  assign do_pop      = pop_i && (count_q != '0);
  assign n_push      = CntW'(push_i.push_a) + CntW'(push_i.push_b);
  assign wr_ptr_d    = wr_ptr_q + PtrW'(n_push);
  assign rd_ptr_d    = rd_ptr_q + PtrW'(do_pop);
  assign count_d     = count_q + n_push - CntW'(do_pop);
  assign rdata_o     = mem[rd_ptr_q];
  assign not_empty_o = (count_q != '0);
  assign room2_o     = (count_q <= CntW'(LgbbFifoDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.push_a) begin
      mem[wr_ptr_q] <= data_a_i;
      if (push_i.push_b) begin
        mem[wr_ptr_q + PtrW'(1)] <= data_b_i;
      end
    end else if (push_i.push_b) begin
      mem[wr_ptr_q] <= data_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> hw/rtl/label_group_bounding_box.sv
// Top level of the label group bounding box block.
// Points enter on the input request channel (in_valid_i, in_stall_o), grouped
// by label, and one point can be taken in every cycle unless the input stalls.
// Each point is held in an input register; once the record queue has room for
// two records it updates the running min and max of the open group and may
// close it. A closed box that fits the size window, and the end-of-cloud record,
// go into a four-entry record queue that drives the output request channel
// (out_valid_o, out_stall_i). A point that yields two records (label change on
// the last point) needs the output to take both, so sustained rate is one point
// per cycle while records are drained one per cycle. The input stalls when a
// point is held and the queue cannot take two more records, so an output stall
// backs up into the input. Reset empties the queue, closes any group and
// restores max_size to 3840 and min_size to 51. Configuration writes go through
// cfg_we_i, cfg_index_i and cfg_data_i and take effect at the next clock edge.
`timescale 1ns / 1ps

module label_group_bounding_box
  import lgbb_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int LABEL_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_index_i,
  input  logic [SizeWidth-1:0]          cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic [LABEL_WIDTH-1:0]        point_label_i,
  input  logic                          cloud_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [LABEL_WIDTH-1:0]        box_label_o,
  output logic signed [COORD_WIDTH-1:0] center_x_o,
  output logic signed [COORD_WIDTH-1:0] center_y_o,
  output logic signed [COORD_WIDTH-1:0] center_z_o,
  output logic [COORD_WIDTH-1:0]        size_x_o,
  output logic [COORD_WIDTH-1:0]        size_y_o,
  output logic [COORD_WIDTH-1:0]        size_z_o,
  output logic                          box_present_o,
  output logic                          cloud_end_o,
  output logic                          run_last_o
);

  localparam int CW = COORD_WIDTH;
  localparam int LW = LABEL_WIDTH;

  typedef struct packed {
    logic [LW-1:0]      label;
    logic [2:0][CW-1:0] center;
    logic [2:0][CW-1:0] size;
    logic               present;
    logic               cend;
    logic               rlast;
  } rec_t;

  localparam int RecW = $bits(rec_t);

  logic [SizeWidth-1:0] max_size_q, min_size_q;

  logic               s1_valid_q, s1_valid_d;
  logic [2:0][CW-1:0] s1_pt_q;
  logic [LW-1:0]      s1_label_q;
  logic               s1_last_q;
  logic               in_accept, advance, room2;

  logic               open_q;
  logic [LW-1:0]      label_q;
  logic [2:0][CW-1:0] hi_q, lo_q, hi_d, lo_d;

  logic               change;
  logic [2:0][CW-1:0] center_a, size_a, center_b, size_b;
  logic               ok_a, ok_b;
  rec_t               rec_a, rec_b, rec_out;
  logic [RecW-1:0]    rdata;
  lgbb_push_t         push;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= LgbbMaxSizeReset;
      min_size_q <= LgbbMinSizeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        LgbbRegMaxSize: max_size_q <= cfg_data_i;
        LgbbRegMinSize: min_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  assign advance    = s1_valid_q && room2;
  assign in_stall_o = s1_valid_q && !room2;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pt_q    <= {point_z_i, point_y_i, point_x_i};
      s1_label_q <= point_label_i;
      s1_last_q  <= cloud_last_i;
    end
  end

  // Group bounds update.
  assign change = open_q && (s1_label_q != label_q);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (!open_q || change) begin
        hi_d[a] = s1_pt_q[a];
        lo_d[a] = s1_pt_q[a];
      end else begin
        hi_d[a] = ($signed(s1_pt_q[a]) > $signed(hi_q[a])) ? s1_pt_q[a] : hi_q[a];
        lo_d[a] = ($signed(s1_pt_q[a]) < $signed(lo_q[a])) ? s1_pt_q[a] : lo_q[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      label_q <= '0;
      hi_q    <= '0;
      lo_q    <= '0;
    end else if (advance) begin
      open_q  <= !s1_last_q;
      label_q <= s1_label_q;
      hi_q    <= hi_d;
      lo_q    <= lo_d;
    end
  end

  // The old group closes on a label change; the updated group closes at cloud end.
  lgbb_close #(
    .CW(CW)
  ) u_close_a (
    .hi_i      (hi_q),
    .lo_i      (lo_q),
    .max_size_i(max_size_q),
    .min_size_i(min_size_q),
    .center_o  (center_a),
    .size_o    (size_a),
    .ok_o      (ok_a)
  );

  lgbb_close #(
    .CW(CW)
  ) u_close_b (
    .hi_i      (hi_d),
    .lo_i      (lo_d),
    .max_size_i(max_size_q),
    .min_size_i(min_size_q),
    .center_o  (center_b),
    .size_o    (size_b),
    .ok_o      (ok_b)
  );

  always_comb begin
    rec_a.label   = label_q;
    rec_a.center  = center_a;
    rec_a.size    = size_a;
    rec_a.present = 1'b1;
    rec_a.cend    = 1'b0;
    rec_a.rlast   = !s1_last_q;

    rec_b.label   = ok_b ? s1_label_q : '0;
    rec_b.center  = center_b;
    rec_b.size    = size_b;
    rec_b.present = ok_b;
    rec_b.cend    = 1'b1;
    rec_b.rlast   = 1'b1;

    push.push_a = advance && change && ok_a;
    push.push_b = advance && s1_last_q;
  end

  lgbb_fifo #(
    .WIDTH(RecW)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .data_a_i   (rec_a),
    .data_b_i   (rec_b),
    .pop_i      (out_valid_o && !out_stall_i),
    .rdata_o    (rdata),
    .not_empty_o(out_valid_o),
    .room2_o    (room2)
  );

  assign rec_out       = rec_t'(rdata);
  assign box_label_o   = rec_out.label;
  assign center_x_o    = rec_out.center[0];
  assign center_y_o    = rec_out.center[1];
  assign center_z_o    = rec_out.center[2];
  assign size_x_o      = rec_out.size[0];
  assign size_y_o      = rec_out.size[1];
  assign size_z_o      = rec_out.size[2];
  assign box_present_o = rec_out.present;
  assign cloud_end_o   = rec_out.cend;
  assign run_last_o    = rec_out.rlast;

  // A point that ends the cloud leaves no group open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_last_q) |=> !open_q)
    else $error("group still open after cloud end");

  // A processed point always sets the group label to its own label.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (label_q == $past(s1_label_q)))
    else $error("group label not taken from processed point");

  // A held point is not lost while the input is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> (s1_valid_q && $stable(s1_label_q) && $stable(s1_pt_q)))
    else $error("held point lost during input stall");

endmodule

>>> verif/lgbb_box_checker.sv
// Checker that predicts the boxes of the label group bounding box block and compares its records.
`timescale 1ns / 1ps

module lgbb_box_checker
  import lgbb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic signed [15:0] point_z_i,
  input  logic [15:0]        point_label_i,
  input  logic               cloud_last_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [15:0]        box_label_o,
  input  logic signed [15:0] center_x_o,
  input  logic signed [15:0] center_y_o,
  input  logic signed [15:0] center_z_o,
  input  logic [15:0]        size_x_o,
  input  logic [15:0]        size_y_o,
  input  logic [15:0]        size_z_o,
  input  logic               box_present_o,
  input  logic               cloud_end_o,
  input  logic               run_last_o,
  output int                 errors_o,
  output int                 pending_o,
  output int                 checked_o
);

  typedef struct packed {
    logic [15:0]        box_label;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [15:0] center_z;
    logic [15:0]        size_x;
    logic [15:0]        size_y;
    logic [15:0]        size_z;
    logic               box_present;
    logic               cloud_end;
    logic               run_last;
  } box_rec_t;

  box_rec_t boxes_due[$];

  logic [15:0]        lim_max = LgbbMaxSizeReset;
  logic [15:0]        lim_min = LgbbMinSizeReset;
  logic               grp_open = 1'b0;
  logic [15:0]        grp_label = '0;
  logic signed [15:0] lo_x = '0, hi_x = '0, lo_y = '0, hi_y = '0, lo_z = '0, hi_z = '0;

  function automatic box_rec_t close_box();
    box_rec_t r;
    logic [16:0] sx, sy, sz;
    logic signed [16:0] cx, cy, cz;
    logic fits;
    sx = {hi_x[15], hi_x} - {lo_x[15], lo_x};
    sy = {hi_y[15], hi_y} - {lo_y[15], lo_y};
    sz = {hi_z[15], hi_z} - {lo_z[15], lo_z};
    cx = $signed({hi_x[15], hi_x}) + $signed({lo_x[15], lo_x});
    cy = $signed({hi_y[15], hi_y}) + $signed({lo_y[15], lo_y});
    cz = $signed({hi_z[15], hi_z}) + $signed({lo_z[15], lo_z});
    fits = (sx <= {1'b0, lim_max}) && (sy <= {1'b0, lim_max}) && (sz <= {1'b0, lim_max}) &&
           (sx >= {1'b0, lim_min}) && (sy >= {1'b0, lim_min}) && (sz >= {1'b0, lim_min});
    r = '0;
    if (fits) begin
      r.box_label = grp_label;
      r.center_x = cx[16:1];
      r.center_y = cy[16:1];
      r.center_z = cz[16:1];
      r.size_x = sx[15:0];
      r.size_y = sy[15:0];
      r.size_z = sz[15:0];
      r.box_present = 1'b1;
    end
    return r;
  endfunction

  task automatic track_point(input logic signed [15:0] px, input logic signed [15:0] py,
                             input logic signed [15:0] pz, input logic [15:0] lab,
                             input logic last);
    box_rec_t r;
    int n_before;
    n_before = boxes_due.size();
    if (grp_open && lab != grp_label) begin
      r = close_box();
      if (r.box_present) boxes_due.insert(boxes_due.size(), r);
      grp_open = 1'b0;
    end
    if (!grp_open) begin
      grp_open = 1'b1;
      grp_label = lab;
      lo_x = px; hi_x = px;
      lo_y = py; hi_y = py;
      lo_z = pz; hi_z = pz;
    end else begin
      if (px > hi_x) hi_x = px;
      if (py > hi_y) hi_y = py;
      if (pz > hi_z) hi_z = pz;
      if (px < lo_x) lo_x = px;
      if (py < lo_y) lo_y = py;
      if (pz < lo_z) lo_z = pz;
    end
    if (last) begin
      r = close_box();
      r.cloud_end = 1'b1;
      boxes_due.insert(boxes_due.size(), r);
      grp_open = 1'b0;
    end
    if (boxes_due.size() > n_before) begin
      r = boxes_due[boxes_due.size() - 1];
      r.run_last = 1'b1;
      boxes_due[boxes_due.size() - 1] = r;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] expv,
                             input logic [15:0] actv);
    if (expv !== actv) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
      errors_o++;
    end
  endtask

  always @(posedge clk_i) begin
    box_rec_t want;
    if (!rst_ni) begin
      lim_max = LgbbMaxSizeReset;
      lim_min = LgbbMinSizeReset;
      grp_open = 1'b0;
      grp_label = '0;
      lo_x = '0; hi_x = '0; lo_y = '0; hi_y = '0; lo_z = '0; hi_z = '0;
      boxes_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          LgbbRegMaxSize: lim_max = cfg_data_i;
          LgbbRegMinSize: lim_min = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (boxes_due.size() == 0) begin
          $error("Unexpected record: label 0x%0h, box_present %0b, cloud_end %0b",
                 box_label_o, box_present_o, cloud_end_o);
          errors_o++;
        end else begin
          want = boxes_due.pop_front();
          checked_o++;
          check_field("box_label", want.box_label, box_label_o);
          check_field("center_x", want.center_x, center_x_o);
          check_field("center_y", want.center_y, center_y_o);
          check_field("center_z", want.center_z, center_z_o);
          check_field("size_x", want.size_x, size_x_o);
          check_field("size_y", want.size_y, size_y_o);
          check_field("size_z", want.size_z, size_z_o);
          check_field("box_present", want.box_present, box_present_o);
          check_field("cloud_end", want.cloud_end, cloud_end_o);
          check_field("run_last", want.run_last, run_last_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        track_point(point_x_i, point_y_i, point_z_i, point_label_i, cloud_last_i);
      end
    end
    pending_o = boxes_due.size();
  end

endmodule

>>> verif/testbench.sv
// Top of the testbench: drives point clouds and register settings into the block and gives the verdict.
`timescale 1ns / 1ps

module testbench
  import lgbb_pkg::*;
;

  localparam int CycleLimit = 400000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [0:0]         cfg_index_i;
  logic [15:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] point_x_i;
  logic signed [15:0] point_y_i;
  logic signed [15:0] point_z_i;
  logic [15:0]        point_label_i;
  logic               cloud_last_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [15:0]        box_label_o;
  logic signed [15:0] center_x_o;
  logic signed [15:0] center_y_o;
  logic signed [15:0] center_z_o;
  logic [15:0]        size_x_o;
  logic [15:0]        size_y_o;
  logic [15:0]        size_z_o;
  logic               box_present_o;
  logic               cloud_end_o;
  logic               run_last_o;

  int chk_errors;
  int chk_pending;
  int chk_checked;

  int          cycles = 0;
  int          points_sent = 0;
  int          settings_used = 1;
  logic        calm = 1'b0;
  logic        in_idle_on = 1'b1;
  logic [15:0] cur_max = LgbbMaxSizeReset;
  logic [15:0] cur_min = LgbbMinSizeReset;

  label_group_bounding_box uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .point_x_i(point_x_i), .point_y_i(point_y_i), .point_z_i(point_z_i),
    .point_label_i(point_label_i), .cloud_last_i(cloud_last_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .box_label_o(box_label_o),
    .center_x_o(center_x_o), .center_y_o(center_y_o), .center_z_o(center_z_o),
    .size_x_o(size_x_o), .size_y_o(size_y_o), .size_z_o(size_z_o),
    .box_present_o(box_present_o), .cloud_end_o(cloud_end_o), .run_last_o(run_last_o)
  );

  lgbb_box_checker box_chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .point_x_i(point_x_i), .point_y_i(point_y_i), .point_z_i(point_z_i),
    .point_label_i(point_label_i), .cloud_last_i(cloud_last_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .box_label_o(box_label_o),
    .center_x_o(center_x_o), .center_y_o(center_y_o), .center_z_o(center_z_o),
    .size_x_o(size_x_o), .size_y_o(size_y_o), .size_z_o(size_z_o),
    .box_present_o(box_present_o), .cloud_end_o(cloud_end_o), .run_last_o(run_last_o),
    .errors_o(chk_errors), .pending_o(chk_pending), .checked_o(chk_checked)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (calm) begin
        out_stall_i <= 1'b0;
        @(negedge clk_i);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 40)) @(negedge clk_i);
      end
    end
  end

  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic signed [15:0] z, input logic [15:0] lab,
                            input logic last);
    @(negedge clk_i);
    if (in_idle_on && !calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    point_z_i <= z;
    point_label_i <= lab;
    cloud_last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    points_sent++;
  endtask

  // Waits until every expected record has arrived and the pipeline has emptied.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (chk_pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic set_limits(input logic [15:0] new_max, input logic [15:0] new_min);
    settle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= LgbbRegMaxSize;
    cfg_data_i <= new_max;
    @(negedge clk_i);
    cfg_index_i <= LgbbRegMinSize;
    cfg_data_i <= new_min;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_max = new_max;
    cur_min = new_min;
    settings_used++;
  endtask

  function automatic int pick_extent(input int kind);
    int e;
    case (kind)
      0: e = $urandom_range(0, cur_min);
      1: e = (cur_min <= cur_max) ? $urandom_range(cur_min, cur_max) : $urandom_range(0, 65535);
      2: e = $urandom_range(0, 65535);
      default: begin
        case ($urandom_range(0, 3))
          0: e = cur_max;
          1: e = cur_max + 1;
          2: e = cur_min;
          default: e = cur_min - 1;
        endcase
        if (e > 65535) e = 65535;
        if (e < 0) e = 0;
      end
    endcase
    return e;
  endfunction

  task automatic run_phase(input int n_items);
    int sent, groups, pts, kind, r;
    int ex, ey, ez, bx, by, bz;
    logic [15:0] lab;
    logic last;
    sent = 0;
    in_idle_on = ($urandom_range(0, 3) != 0);
    while (sent < n_items) begin
      groups = $urandom_range(1, 8);
      lab = 16'($urandom);
      for (int g = 0; g < groups; g++) begin
        pts = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        r = $urandom_range(0, 19);
        kind = (r < 3) ? 0 : (r < 13) ? 1 : (r < 16) ? 2 : 3;
        ex = pick_extent(kind);
        ey = pick_extent(kind);
        ez = pick_extent(kind);
        bx = $urandom_range(0, 65535 - ex) - 32768;
        by = $urandom_range(0, 65535 - ey) - 32768;
        bz = $urandom_range(0, 65535 - ez) - 32768;
        for (int p = 0; p < pts; p++) begin
          last = (g == groups - 1) && (p == pts - 1);
          if ($urandom_range(0, 11) == 0) begin
            send_point(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       $urandom_range(0, 7) == 0);
          end else if (p == 0) begin
            send_point(16'(bx), 16'(by), 16'(bz), lab, last);
          end else if (p == 1) begin
            send_point(16'(bx + ex), 16'(by + ey), 16'(bz + ez), lab, last);
          end else begin
            send_point(16'(bx + $urandom_range(0, ex)), 16'(by + $urandom_range(0, ey)),
                       16'(bz + $urandom_range(0, ez)), lab, last);
          end
          sent++;
        end
        lab = ($urandom_range(0, 1) == 0) ? 16'(lab + $urandom_range(1, 3)) : 16'($urandom);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = LgbbRegMaxSize;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    point_x_i = '0;
    point_y_i = '0;
    point_z_i = '0;
    point_label_i = '0;
    cloud_last_i = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // A lone point that also ends the cloud, then boxes at both limits of the window.
    send_point(16'sd32767, -16'sd32768, 16'sd0, 16'hFFFF, 1'b1);
    send_point(16'sd0, 16'sd0, 16'sd0, 16'd1, 1'b0);
    send_point(16'sd100, 16'sd200, 16'sd300, 16'd1, 1'b0);
    send_point(-16'sd1, -16'sd1, -16'sd1, 16'd2, 1'b0);
    send_point(-16'sd3841, -16'sd52, -16'sd52, 16'd2, 1'b1);
    send_point(16'sd10, 16'sd10, 16'sd10, 16'd3, 1'b0);
    send_point(16'sd20, 16'sd20, 16'sd20, 16'd3, 1'b0);
    send_point(16'sd0, 16'sd0, 16'sd0, 16'd4, 1'b1);
    send_point(-16'sd101, -16'sd101, -16'sd101, 16'd7, 1'b0);
    send_point(16'sd0, 16'sd0, 16'sd0, 16'd7, 1'b0);
    send_point(16'sd5, 16'sd5, 16'sd5, 16'd8, 1'b1);
    send_point(16'sd0, 16'sd0, 16'sd0, 16'd9, 1'b0);
    send_point(16'sd3841, 16'sd0, 16'sd0, 16'd9, 1'b0);
    send_point(16'sd0, 16'sd51, 16'sd50, 16'd9, 1'b1);

    set_limits(16'hFFFF, 16'h0000);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768, 16'd0, 1'b0);
    send_point(16'sd32767, 16'sd32767, 16'sd32767, 16'd0, 1'b1);
    send_point(16'sd1, 16'sd2, 16'sd3, 16'hAAAA, 1'b1);

    // With the minimum above the maximum no box can pass.
    set_limits(16'h0000, 16'hFFFF);
    send_point(16'sd0, 16'sd0, 16'sd0, 16'h5555, 1'b0);
    send_point(16'sd100, 16'sd100, 16'sd100, 16'h5555, 1'b1);

    set_limits(LgbbMaxSizeReset, LgbbMinSizeReset);
    run_phase(300);
    set_limits(16'hFFFF, 16'h0000);
    run_phase(250);
    set_limits(16'h0000, 16'hFFFF);
    run_phase(150);
    set_limits(16'($urandom), 16'($urandom_range(0, 400)));
    run_phase(250);
    set_limits(16'h0000, 16'h0000);
    run_phase(150);
    set_limits(16'hFFFF, 16'hFFFF);
    run_phase(100);
    set_limits(16'($urandom_range(100, 2000)), 16'($urandom_range(0, 200)));
    run_phase(300);
    set_limits(LgbbMaxSizeReset, LgbbMinSizeReset);
    calm = 1'b1;
    run_phase(450);

    settle();
    repeat (10) @(negedge clk_i);
    $display("Sent %0d points under %0d size windows, both limits at 0 and 65535 included.",
             points_sent, settings_used);
    $display("Compared %0d box records field by field.", chk_checked);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
